// ===== hdl/hwpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hwpf_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int MAX_NEIGHBORS = 64;
   localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
   localparam int SUM_W         = 48;
   localparam int ACC_W         = 96;
   localparam int CSR_AW        = 5;

   // iterative unit widths and steps
   localparam int DIV_STEP   = 4;
   localparam int DIV_ITER   = 64 / DIV_STEP;
   localparam int DIV_CW     = $clog2(DIV_ITER);
   localparam int SQRT_STEP  = 2;
   localparam int SQRT_ITER  = 32 / SQRT_STEP;
   localparam int SQRT_CW    = $clog2(SQRT_ITER);

   localparam logic [46:0] CAP47 = {47{1'b1}};
   localparam logic [62:0] CAP62 = {1'b1, 62'd0};

   // register indexes
   localparam logic [2:0] REG_K_ATT    = 3'd0;
   localparam logic [2:0] REG_K_REP    = 3'd1;
   localparam logic [2:0] REG_D_SAFE   = 3'd2;
   localparam logic [2:0] REG_INV_MASS = 3'd3;
   localparam logic [2:0] REG_MISSION  = 3'd4;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      abs32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [SUM_W-1:0] sat48(input logic signed [SUM_W+1:0] v);
      if (v > $signed({3'b000, CAP47})) begin
         sat48 = {1'b0, CAP47};
      end else if (v < -$signed({3'b000, CAP47}) - 50'sd1) begin
         sat48 = {1'b1, 47'd0};
      end else begin
         sat48 = v[SUM_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/hwpf_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hwpf_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [7:0]         own_hops;
   logic [7:0]         peer_hops;
   logic signed [31:0] offset_x;
   logic signed [31:0] offset_y;
   logic signed [31:0] offset_z;

   modport source(output valid, mode, own_hops, peer_hops, offset_x, offset_y, offset_z,
                  input ready);
   modport sink(input valid, mode, own_hops, peer_hops, offset_x, offset_y, offset_z,
                output ready);
endinterface

interface hwpf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_x;
   logic signed [31:0] accel_y;
   logic signed [31:0] accel_z;
   logic               idle;

   modport source(output valid, accel_x, accel_y, accel_z, idle, input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, idle, output ready);
endinterface
`default_nettype wire

// ===== hdl/hwpf_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hwpf_mul (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [63:0] prod
);

   logic [63:0] prod_ff;

   // register the product every cycle
   always_ff @(posedge clock) begin
      prod_ff <= 64'(a) * 64'(b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== hdl/hwpf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hwpf_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hwpf_pkg::div_req_type req,
   output logic                      done,
   output logic [63:0]               quotient
);

   logic [31:0]                 rem_ff, rem_in;
   logic [63:0]                 quo_ff, quo_in;
   logic [31:0]                 dsr_ff, dsr_in;
   logic [hwpf_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [32:0]                 trial;

   // restoring division, a few quotient bits per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = hwpf_pkg::DIV_CW'(hwpf_pkg::DIV_ITER - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < hwpf_pkg::DIV_STEP; i++) begin
            trial  = {rem_in, quo_in[63]};
            quo_in = {quo_in[62:0], 1'b0};
            if (trial >= {1'b0, dsr_ff}) begin
               trial     = trial - {1'b0, dsr_ff};
               quo_in[0] = 1'b1;
            end
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= '0;
         dsr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dsr_ff  <= dsr_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== hdl/hwpf_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hwpf_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hwpf_pkg::sqrt_req_type req,
   output logic                       done,
   output logic [31:0]                root
);

   logic [33:0]                  rem_ff, rem_in;
   logic [31:0]                  root_ff, root_in;
   logic [63:0]                  rad_ff, rad_in;
   logic [hwpf_pkg::SQRT_CW-1:0] cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [35:0]                  work;
   logic [35:0]                  trial;

   // digit-by-digit root, two radicand bits per digit
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      rad_in  = rad_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      work    = '0;
      trial   = '0;
      if (req.start) begin
         rem_in  = '0;
         root_in = '0;
         rad_in  = req.radicand;
         cnt_in  = hwpf_pkg::SQRT_CW'(hwpf_pkg::SQRT_ITER - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < hwpf_pkg::SQRT_STEP; i++) begin
            work   = {rem_in, rad_in[63:62]};
            rad_in = {rad_in[61:0], 2'b00};
            trial  = {2'b00, root_in, 2'b01};
            if (work >= trial) begin
               work    = work - trial;
               root_in = {root_in[30:0], 1'b1};
            end else begin
               root_in = {root_in[30:0], 1'b0};
            end
            rem_in = work[33:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
         rad_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== hdl/hop_weighted_potential_field.sv =====
`timescale 1ns / 1ps
`default_nettype none
// With repulsion, a neighbor report runs up to three divisions per axis on the shared
// 4-bit-per-cycle divider.
// A finish request runs two 64-by-32 multiplies per axis, each as two passes on one
// 32-bit multiplier; a held result stalls it.
// Throughput: one request at a time; ready is high only between requests.
// Reset (synchronous, active high) loads the register defaults and clears all sums.
module hop_weighted_potential_field (
   input  wire logic                       clock,
   input  wire logic                       reset,
   hwpf_req_if.sink                        req,
   hwpf_rsp_if.source                      rsp,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [hwpf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic      [31:0]                csr_prdata,
   output logic                            csr_pready
);

   localparam int F  = hwpf_pkg::FRAC_BITS;
   localparam int SW = hwpf_pkg::SUM_W;
   localparam int CW = hwpf_pkg::CNT_W;
   localparam int AW = hwpf_pkg::ACC_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SQ, S_SQ_ACC, S_SQRT_GO, S_SQRT, S_RM, S_RDIV0, S_RDIV1,
      S_RDIV2, S_RDIV3, S_RACC, S_FA, S_FM0, S_FM1, S_FM2, S_FF, S_GM0, S_GM1, S_GM2, S_GS
   } state_type;

   // configuration registers
   logic [31:0] k_att_ff, k_rep_ff, d_safe_ff, inv_mass_ff;
   logic        mission_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_att_ff    <= 32'h0001_0000;
         k_rep_ff    <= 32'h0001_0000;
         d_safe_ff   <= 32'h0002_0000;
         inv_mass_ff <= 32'h0001_0000;
         mission_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            hwpf_pkg::REG_K_ATT:    k_att_ff    <= csr_pwdata;
            hwpf_pkg::REG_K_REP:    k_rep_ff    <= csr_pwdata;
            hwpf_pkg::REG_D_SAFE:   d_safe_ff   <= csr_pwdata;
            hwpf_pkg::REG_INV_MASS: inv_mass_ff <= csr_pwdata;
            hwpf_pkg::REG_MISSION:  mission_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[4:2])
         hwpf_pkg::REG_K_ATT:    csr_prdata = k_att_ff;
         hwpf_pkg::REG_K_REP:    csr_prdata = k_rep_ff;
         hwpf_pkg::REG_D_SAFE:   csr_prdata = d_safe_ff;
         hwpf_pkg::REG_INV_MASS: csr_prdata = inv_mass_ff;
         hwpf_pkg::REG_MISSION:  csr_prdata = {31'd0, mission_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // sequencer state
   state_type                state_ff, state_in;
   logic [1:0]               axis_ff, axis_in;
   logic                     mode_ff, mode_in;
   logic [7:0]               own_ff, own_in, nbr_ff, nbr_in;
   logic signed [31:0]       off_ff [3];
   logic signed [31:0]       off_in [3];
   logic [CW-1:0]            taken_ff, taken_in, lcnt_ff, lcnt_in, hcnt_ff, hcnt_in;
   logic [SW-1:0]            lsum_ff [3];
   logic [SW-1:0]            lsum_in [3];
   logic [SW-1:0]            hsum_ff [3];
   logic [SW-1:0]            hsum_in [3];
   logic [SW-1:0]            rsum_ff [3];
   logic [SW-1:0]            rsum_in [3];
   logic [63:0]              sq_ff, sq_in;
   logic [31:0]              d_ff, d_in;
   logic [AW-1:0]            acc_ff, acc_in;
   logic [62:0]              mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [46:0]              r_ff, r_in;
   logic [31:0]              res_ff [2];
   logic [31:0]              res_in [2];
   logic [31:0]              accel_ff [3];
   logic [31:0]              accel_in [3];
   logic                     idle_ff, idle_in;
   logic                     rvalid_ff, rvalid_in;

   // shared units
   logic [31:0]              mul_a, mul_b;
   logic [63:0]              mul_p;
   hwpf_pkg::div_req_type    div_req;
   logic                     div_done;
   logic [63:0]              div_quo;
   hwpf_pkg::sqrt_req_type   sqrt_req;
   logic                     sqrt_done;
   logic [31:0]              sqrt_root;

   hwpf_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(mul_p));
   hwpf_div u_div (.clock(clock), .reset(reset), .req(div_req), .done(div_done),
                   .quotient(div_quo));
   hwpf_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .done(sqrt_done),
                     .root(sqrt_root));

   // datapath temporaries
   logic                     out_free;
   logic [31:0]              cur_mag;
   logic signed [55:0]       a_val;
   logic [55:0]              a_abs;
   logic [AW-F-1:0]          t_sh;
   logic [62:0]              t1c;
   logic signed [64:0]       f_val;
   logic [64:0]              f_abs;
   logic [31:0]              out_val;
   logic signed [SW+1:0]     radd;

   assign out_free = !rvalid_ff || rsp.ready;
   assign cur_mag  = hwpf_pkg::abs32(off_ff[axis_ff]);
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      mode_in   = mode_ff;
      own_in    = own_ff;
      nbr_in    = nbr_ff;
      off_in    = off_ff;
      taken_in  = taken_ff;
      lcnt_in   = lcnt_ff;
      hcnt_in   = hcnt_ff;
      lsum_in   = lsum_ff;
      hsum_in   = hsum_ff;
      rsum_in   = rsum_ff;
      sq_in     = sq_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      r_in      = r_ff;
      res_in    = res_ff;
      accel_in  = accel_ff;
      idle_in   = idle_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      mul_a     = '0;
      mul_b     = '0;
      div_req   = '0;
      sqrt_req.start    = 1'b0;
      sqrt_req.radicand = sq_ff;
      a_val   = $signed({1'b0, hcnt_ff}) * $signed(lsum_ff[axis_ff])
              + $signed({1'b0, lcnt_ff}) * $signed(hsum_ff[axis_ff]);
      a_abs   = a_val[55] ? 56'(-a_val) : 56'(a_val);
      t_sh    = acc_ff[AW-1:F];
      t1c     = (t_sh > (AW-F)'(hwpf_pkg::CAP62)) ? hwpf_pkg::CAP62 : t_sh[62:0];
      f_val   = (neg_ff ? -$signed({2'b00, t1c}) : $signed({2'b00, t1c}))
              + $signed({{(65-SW){rsum_ff[axis_ff][SW-1]}}, rsum_ff[axis_ff]});
      f_abs   = f_val[64] ? 65'(-f_val) : 65'(f_val);
      if (t_sh >= (AW-F)'(64'h8000_0000)) begin
         out_val = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         out_val = neg_ff ? 32'(-t_sh[31:0]) : t_sh[31:0];
      end
      radd = off_ff[axis_ff][31]
           ? $signed({{2{rsum_ff[axis_ff][SW-1]}}, rsum_ff[axis_ff]}) + $signed({3'b000, r_ff})
           : $signed({{2{rsum_ff[axis_ff][SW-1]}}, rsum_ff[axis_ff]}) - $signed({3'b000, r_ff});

      case (state_ff)
         S_IDLE: begin
            // take a request
            if (req.valid) begin
               mode_in   = req.mode;
               own_in    = req.own_hops;
               nbr_in    = req.peer_hops;
               off_in[0] = req.offset_x;
               off_in[1] = req.offset_y;
               off_in[2] = req.offset_z;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            axis_in = '0;
            if (mode_ff) begin
               if (!mission_ff) begin
                  // emit idle result and clear sums
                  if (out_free) begin
                     accel_in  = '{default: '0};
                     idle_in   = 1'b1;
                     rvalid_in = 1'b1;
                     lsum_in   = '{default: '0};
                     hsum_in   = '{default: '0};
                     rsum_in   = '{default: '0};
                     lcnt_in   = '0;
                     hcnt_in   = '0;
                     taken_in  = '0;
                     state_in  = S_IDLE;
                  end
               end else begin
                  state_in = S_FA;
               end
            end else if (!mission_ff || taken_ff >= CW'(hwpf_pkg::MAX_NEIGHBORS)) begin
               // drop the report
               state_in = S_IDLE;
            end else begin
               taken_in = taken_ff + 1'b1;
               if (nbr_ff < own_ff) begin
                  lcnt_in = lcnt_ff + 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     lsum_in[i] = hwpf_pkg::sat48($signed({{2{lsum_ff[i][SW-1]}}, lsum_ff[i]})
                                + $signed({{(SW-30){off_ff[i][31]}}, off_ff[i]}));
                  end
               end else if (nbr_ff > own_ff) begin
                  hcnt_in = hcnt_ff + 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     hsum_in[i] = hwpf_pkg::sat48($signed({{2{hsum_ff[i][SW-1]}}, hsum_ff[i]})
                                + $signed({{(SW-30){off_ff[i][31]}}, off_ff[i]}));
                  end
               end
               sq_in    = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            mul_a    = cur_mag;
            mul_b    = cur_mag;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            // accumulate squared distance
            sq_in = sq_ff + mul_p;
            if (axis_ff == 2'd2) begin
               state_in = S_SQRT_GO;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQRT_GO: begin
            sqrt_req.start = 1'b1;
            state_in       = S_SQRT;
         end
         S_SQRT: begin
            if (sqrt_done) begin
               d_in    = sqrt_root;
               axis_in = '0;
               if (sqrt_root != '0 && sqrt_root < d_safe_ff) begin
                  state_in = S_RM;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RM: begin
            mul_a    = cur_mag;
            mul_b    = k_rep_ff;
            state_in = S_RDIV0;
         end
         S_RDIV0: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_p;
            div_req.divisor  = d_ff;
            state_in         = S_RDIV1;
         end
         S_RDIV1: begin
            if (div_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {div_quo[63-F:0], F'(0)};
               div_req.divisor  = d_ff;
               state_in         = S_RDIV2;
            end
         end
         S_RDIV2: begin
            if (div_done) begin
               if (div_quo[63:64-F] != '0) begin
                  r_in     = hwpf_pkg::CAP47;
                  state_in = S_RACC;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {div_quo[63-F:0], F'(0)};
                  div_req.divisor  = d_ff;
                  state_in         = S_RDIV3;
               end
            end
         end
         S_RDIV3: begin
            if (div_done) begin
               r_in     = (div_quo[63:47] != '0) ? hwpf_pkg::CAP47 : div_quo[46:0];
               state_in = S_RACC;
            end
         end
         S_RACC: begin
            // push away from the neighbor
            rsum_in[axis_ff] = hwpf_pkg::sat48(radd);
            if (axis_ff == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_RM;
            end
         end
         S_FA: begin
            neg_in   = a_val[55];
            mag_in   = 63'(a_abs);
            state_in = S_FM0;
         end
         S_FM0: begin
            mul_a    = mag_ff[31:0];
            mul_b    = k_att_ff;
            state_in = S_FM1;
         end
         S_FM1: begin
            acc_in   = AW'(mul_p);
            mul_a    = {1'b0, mag_ff[62:32]};
            mul_b    = k_att_ff;
            state_in = S_FM2;
         end
         S_FM2: begin
            acc_in   = acc_ff + {mul_p, 32'd0};
            state_in = S_FF;
         end
         S_FF: begin
            // add repulsion to the scaled attraction
            neg_in   = f_val[64];
            mag_in   = f_abs[62:0];
            state_in = S_GM0;
         end
         S_GM0: begin
            mul_a    = mag_ff[31:0];
            mul_b    = inv_mass_ff;
            state_in = S_GM1;
         end
         S_GM1: begin
            acc_in   = AW'(mul_p);
            mul_a    = {1'b0, mag_ff[62:32]};
            mul_b    = inv_mass_ff;
            state_in = S_GM2;
         end
         S_GM2: begin
            acc_in   = acc_ff + {mul_p, 32'd0};
            state_in = S_GS;
         end
         S_GS: begin
            if (axis_ff != 2'd2) begin
               res_in[axis_ff[0]] = out_val;
               axis_in            = axis_ff + 1'b1;
               state_in           = S_FA;
            end else if (out_free) begin
               // emit acceleration and clear sums
               accel_in[0] = res_ff[0];
               accel_in[1] = res_ff[1];
               accel_in[2] = out_val;
               idle_in     = 1'b0;
               rvalid_in   = 1'b1;
               lsum_in     = '{default: '0};
               hsum_in     = '{default: '0};
               rsum_in     = '{default: '0};
               lcnt_in     = '0;
               hcnt_in     = '0;
               taken_in    = '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         axis_ff   <= '0;
         mode_ff   <= 1'b0;
         own_ff    <= '0;
         nbr_ff    <= '0;
         off_ff    <= '{default: '0};
         taken_ff  <= '0;
         lcnt_ff   <= '0;
         hcnt_ff   <= '0;
         lsum_ff   <= '{default: '0};
         hsum_ff   <= '{default: '0};
         rsum_ff   <= '{default: '0};
         sq_ff     <= '0;
         d_ff      <= '0;
         acc_ff    <= '0;
         mag_ff    <= '0;
         neg_ff    <= 1'b0;
         r_ff      <= '0;
         res_ff    <= '{default: '0};
         accel_ff  <= '{default: '0};
         idle_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         mode_ff   <= mode_in;
         own_ff    <= own_in;
         nbr_ff    <= nbr_in;
         off_ff    <= off_in;
         taken_ff  <= taken_in;
         lcnt_ff   <= lcnt_in;
         hcnt_ff   <= hcnt_in;
         lsum_ff   <= lsum_in;
         hsum_ff   <= hsum_in;
         rsum_ff   <= rsum_in;
         sq_ff     <= sq_in;
         d_ff      <= d_in;
         acc_ff    <= acc_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         r_ff      <= r_in;
         res_ff    <= res_in;
         accel_ff  <= accel_in;
         idle_ff   <= idle_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp.valid   = rvalid_ff;
   assign rsp.accel_x = accel_ff[0];
   assign rsp.accel_y = accel_ff[1];
   assign rsp.accel_z = accel_ff[2];
   assign rsp.idle    = idle_ff;

   // idle results carry zero acceleration
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.idle |-> accel_ff[0] == '0 && accel_ff[1] == '0 && accel_ff[2] == '0)
      else $error("idle result with nonzero acceleration");

   // report count stays within the neighbor limit
   assert property (@(posedge clock) disable iff (reset)
      taken_ff <= CW'(hwpf_pkg::MAX_NEIGHBORS))
      else $error("neighbor count over limit");

   // lower and higher counts never exceed the reports taken
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, lcnt_ff} + {1'b0, hcnt_ff}) <= {1'b0, taken_ff})
      else $error("hop counts exceed reports taken");

   // repulsion divides only by a nonzero distance inside the safety range
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RDIV0 |-> d_ff != '0 && d_ff < d_safe_ff)
      else $error("division by out-of-range distance");

endmodule
`default_nettype wire
